[hdl/egsr_pkg.sv]
// shared types and constants for the exposure/gain to sensor register block
// no dependencies
package egsr_pkg;

  localparam int unsigned QuotW = 16;
  localparam int unsigned NumW  = 64;
  localparam int unsigned DenW  = 48;
  localparam int unsigned Lat   = QuotW + 1;

  typedef enum logic [2:0] {
    REG_FRAME_NUM   = 3'd0,
    REG_PIXEL_CLK   = 3'd1,
    REG_EXPO_DIV    = 3'd2,
    REG_GAIN_SCALE  = 3'd3,
    REG_MIN_COARSE  = 3'd4,
    REG_COARSE_MARG = 3'd5,
    REG_MIN_GAIN    = 3'd6,
    REG_MAX_GAIN    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [47:0] frame_numerator;
    logic [31:0] pix_clk;
    logic [47:0] exposure_divisor;
    logic [31:0] gain_scale;
    logic [15:0] min_coarse;
    logic [15:0] coarse_margin;
    logic [7:0]  min_gain_code;
    logic [7:0]  max_gain_code;
  } cfg_t;

  // item as it sits in the queue between front and back
  typedef struct packed {
    logic [31:0] frame_rate;
    logic [63:0] product;
    logic [31:0] gain;
    logic        gain_zero;
    logic        err;
  } entry_t;

endpackage

[hdl/egsr_if.sv]
// valid/ready channel interfaces for input and result items
// depends on nothing
interface egsr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_rate_raw;
  logic [31:0] expo_time;
  logic [31:0] gain_req;
  modport source(output valid, frame_rate_raw, expo_time, gain_req, input ready);
  modport sink(input valid, frame_rate_raw, expo_time, gain_req, output ready);
endinterface

interface egsr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  coarse_high;
  logic [7:0]  coarse_low;
  logic [7:0]  gain_code;
  logic [15:0] frame_lines;
  logic        divide_error;
  modport source(output valid, coarse_high, coarse_low, gain_code, frame_lines,
                 divide_error, input ready);
  modport sink(input valid, coarse_high, coarse_low, gain_code, frame_lines,
               divide_error, output ready);
endinterface

[hdl/egsr_front.sv]
// front end: accepts items, flags zero divisors, forms exposure product
// depends on egsr_pkg
module egsr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  egsr_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       frame_rate_i,
  input  logic [31:0]       exposure_i,
  input  logic [31:0]       gain_i,
  output logic              push_o,
  output egsr_pkg::entry_t  entry_o,
  input  logic              full_i
);
  logic             valid_q, valid_d;
  egsr_pkg::entry_t entry_q, entry_d;
  logic             acc;

  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign entry_o    = entry_q;

  // classify and multiply
  always_comb begin
    valid_d = acc ? 1'b1 : (push_o ? 1'b0 : valid_q);
    entry_d = entry_q;
    if (acc) begin
      entry_d.frame_rate = frame_rate_i;
      entry_d.gain       = gain_i;
      entry_d.product    = {32'b0, exposure_i} * {32'b0, cfg_i.pix_clk};
      entry_d.gain_zero  = (gain_i == 32'b0);
      entry_d.err        = (frame_rate_i == 32'b0) || (gain_i == 32'b0) ||
                           (cfg_i.exposure_divisor == 48'b0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end
endmodule

[hdl/egsr_fifo.sv]
// two-entry queue between front and back
// depends on egsr_pkg
module egsr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  egsr_pkg::entry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output egsr_pkg::entry_t data_o
);
  egsr_pkg::entry_t mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

[hdl/egsr_div.sv]
// pipelined restoring divider, 16-bit quotient saturating at all ones
// depends on egsr_pkg
module egsr_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [egsr_pkg::NumW-1:0]  num_i,
  input  logic [egsr_pkg::DenW-1:0]  den_i,
  output logic [egsr_pkg::QuotW-1:0] quot_o
);
  localparam int unsigned N = egsr_pkg::QuotW;

  logic [egsr_pkg::NumW-1:0]  rem_q [N+1];
  logic [egsr_pkg::DenW-1:0]  den_q [N+1];
  logic [N-1:0]               quo_q [N+1];
  logic                       sat_q [N+1];

  logic [egsr_pkg::NumW-1:0]  rem_d [N];
  logic [N-1:0]               quo_d [N];

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [egsr_pkg::NumW-1:0] dsh;
    assign dsh = {{(egsr_pkg::NumW-egsr_pkg::DenW){1'b0}}, den_q[k]} << (N-1-k);
    always_comb begin
      rem_d[k] = rem_q[k];
      quo_d[k] = quo_q[k];
      if (rem_q[k] >= dsh) begin
        rem_d[k] = rem_q[k] - dsh;
        quo_d[k][N-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      // quotient does not fit in N bits (also zero divisor)
      sat_q[0] <= num_i >= {den_i, {N{1'b0}}};
      for (int k = 0; k < N; k++) begin
        rem_q[k+1] <= rem_d[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= quo_d[k];
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  assign quot_o = sat_q[N] ? {N{1'b1}} : quo_q[N];
endmodule

[hdl/egsr_back.sv]
// back end: three dividers, clamping and the result register
// depends on egsr_pkg, egsr_div
module egsr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  egsr_pkg::cfg_t   cfg_i,
  input  logic             empty_i,
  input  egsr_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       coarse_high_o,
  output logic [7:0]       coarse_low_o,
  output logic [7:0]       gain_code_o,
  output logic [15:0]      frame_lines_o,
  output logic             divide_error_o
);
  localparam int unsigned L = egsr_pkg::Lat;

  logic        en;
  logic        vld_q [L];
  logic        err_q [L];
  logic        gz_q [L];
  logic        ov_q, ov_d;
  logic [15:0] frame, coarse, qgain;
  logic [15:0] coarse_d, coarse_q, frame_q;
  logic [7:0]  gain_d, gain_q;
  logic        err_out_q;
  logic signed [17:0] upper, gval;

  assign en    = !ov_q || out_ready_i;
  assign pop_o = en && !empty_i;

  egsr_div u_div_frame (
    .clk_i (clk_i), .en_i (en),
    .num_i ({16'b0, cfg_i.frame_numerator}),
    .den_i ({16'b0, entry_i.frame_rate}),
    .quot_o(frame)
  );

  egsr_div u_div_coarse (
    .clk_i (clk_i), .en_i (en),
    .num_i (entry_i.product),
    .den_i (cfg_i.exposure_divisor),
    .quot_o(coarse)
  );

  egsr_div u_div_gain (
    .clk_i (clk_i), .en_i (en),
    .num_i ({24'b0, cfg_i.gain_scale, 8'b0}),
    .den_i ({16'b0, entry_i.gain}),
    .quot_o(qgain)
  );

  // clamping of coarse time and gain code
  always_comb begin
    upper = $signed({2'b0, frame}) - $signed({2'b0, cfg_i.coarse_margin});
    if ((coarse < cfg_i.min_coarse) || (upper < $signed({2'b0, cfg_i.min_coarse}))) begin
      coarse_d = cfg_i.min_coarse;
    end else if ($signed({2'b0, coarse}) > upper) begin
      coarse_d = upper[15:0];
    end else begin
      coarse_d = coarse;
    end
    // zero gain starts from the lower limit before clamping
    if (gz_q[L-1]) begin
      gval = $signed({10'b0, cfg_i.min_gain_code});
    end else begin
      gval = 18'sd256 - $signed({2'b0, qgain});
    end
    if (gval < $signed({10'b0, cfg_i.min_gain_code})) begin
      gain_d = cfg_i.min_gain_code;
    end else if (gval > $signed({10'b0, cfg_i.max_gain_code})) begin
      gain_d = cfg_i.max_gain_code;
    end else begin
      gain_d = gval[7:0];
    end
    ov_d = en ? vld_q[L-1] : ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < L; k++) begin
        vld_q[k] <= 1'b0;
      end
      ov_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q[0] <= !empty_i;
        for (int k = 1; k < L; k++) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q[0] <= entry_i.err;
      gz_q[0]  <= entry_i.gain_zero;
      for (int k = 1; k < L; k++) begin
        err_q[k] <= err_q[k-1];
        gz_q[k]  <= gz_q[k-1];
      end
      coarse_q  <= coarse_d;
      frame_q   <= frame;
      gain_q    <= gain_d;
      err_out_q <= err_q[L-1];
    end
  end

  assign out_valid_o    = ov_q;
  assign coarse_high_o  = coarse_q[15:8];
  assign coarse_low_o   = coarse_q[7:0];
  assign gain_code_o    = gain_q;
  assign frame_lines_o  = frame_q;
  assign divide_error_o = err_out_q;
endmodule

[hdl/exposure_gain_to_sensor_regs_top.sv]
// path from input accept to result valid: front register, two-entry queue, divider pipelines, result register
// throughput: one item per cycle while the output is not stalled, through the 17-stage divider pipelines
// reset: asynchronous, active low; empties queue and pipeline and loads
// the configuration registers with their default values
// depends on egsr_pkg, egsr_if, egsr_front, egsr_fifo, egsr_back
module exposure_gain_to_sensor_regs_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  egsr_in_if.sink     in_ch,
  egsr_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);
  egsr_pkg::cfg_t   cfg_q, cfg_d;
  egsr_pkg::entry_t f_entry, q_entry;
  logic push, full, pop, empty;

  // configuration register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (egsr_pkg::reg_idx_e'(cfg_idx_i))
        egsr_pkg::REG_FRAME_NUM:   cfg_d.frame_numerator  = cfg_data_i;
        egsr_pkg::REG_PIXEL_CLK:   cfg_d.pix_clk          = cfg_data_i[31:0];
        egsr_pkg::REG_EXPO_DIV:    cfg_d.exposure_divisor = cfg_data_i;
        egsr_pkg::REG_GAIN_SCALE:  cfg_d.gain_scale       = cfg_data_i[31:0];
        egsr_pkg::REG_MIN_COARSE:  cfg_d.min_coarse       = cfg_data_i[15:0];
        egsr_pkg::REG_COARSE_MARG: cfg_d.coarse_margin    = cfg_data_i[15:0];
        egsr_pkg::REG_MIN_GAIN:    cfg_d.min_gain_code    = cfg_data_i[7:0];
        egsr_pkg::REG_MAX_GAIN:    cfg_d.max_gain_code    = cfg_data_i[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_numerator  <= 48'd182400000;
      cfg_q.pix_clk          <= 32'd182400000;
      cfg_q.exposure_divisor <= 48'd3448000000;
      cfg_q.gain_scale       <= 32'd16;
      cfg_q.min_coarse       <= 16'd1;
      cfg_q.coarse_margin    <= 16'd4;
      cfg_q.min_gain_code    <= 8'd0;
      cfg_q.max_gain_code    <= 8'd232;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  egsr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .frame_rate_i(in_ch.frame_rate_raw),
    .exposure_i  (in_ch.expo_time),
    .gain_i      (in_ch.gain_req),
    .push_o      (push),
    .entry_o     (f_entry),
    .full_i      (full)
  );

  egsr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (f_entry),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (q_entry)
  );

  egsr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (empty),
    .entry_i       (q_entry),
    .pop_o         (pop),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .coarse_high_o (out_ch.coarse_high),
    .coarse_low_o  (out_ch.coarse_low),
    .gain_code_o   (out_ch.gain_code),
    .frame_lines_o (out_ch.frame_lines),
    .divide_error_o(out_ch.divide_error)
  );
endmodule

[hdl/egsr_chk.sv]
// port-level checks on the top level, attached by bind
// depends on egsr_if through the bound top level
module egsr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i
);
  // a stalled result keeps its valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped under stall");

  // the queue is empty out of reset, so input is taken at once
  a_ready_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_ready_i)
    else $error("input not ready after reset");

  // pipeline is empty after reset: no result in the first cycles
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_i ##1 !out_valid_i)
    else $error("result appeared too soon after reset");

  // input without output back-pressure never stalls the front
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && $past(!out_valid_i) && $past(!out_valid_i, 2) |-> in_ready_i)
    else $error("input stalled while output idle");
endmodule

bind exposure_gain_to_sensor_regs_top egsr_chk u_egsr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready)
);
